FILE: hdl/pid_position_axis_controller_top_assert.svh
// assertion macros shared by the axis controller
`ifndef PID_POSITION_AXIS_CONTROLLER_TOP_ASSERT_SVH
`define PID_POSITION_AXIS_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define PPAC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPAC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ppac_pkg.sv
package ppac_pkg;

   // field widths
   localparam int POS_W          = 16;
   localparam int MS_W           = 16;
   localparam int GAIN_W         = 24;
   localparam int DEADBAND_W     = 15;
   localparam int DUTY_W         = 10;
   localparam int GAIN_FRAC_BITS = 16;

   // datapath widths
   localparam int ERR_W        = POS_W + 1;
   localparam int DIFF_W       = ERR_W + 1;
   localparam int INTEG_W      = 48;
   localparam int ACC_W        = INTEG_W + 1;
   localparam int INTEG_HALF_W = INTEG_W / 2;
   localparam int IPROD_W      = 2 * POS_W;
   localparam int PMAG_W       = POS_W + GAIN_W;
   localparam int MUL_A_W      = 32;
   localparam int MUL_B_W      = GAIN_W;
   localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
   localparam int SUM_W        = 64;
   localparam int DRIVE_W      = SUM_W - GAIN_FRAC_BITS;

   // long divider
   localparam int NUM_W          = 72;
   localparam int DIV_W          = MS_W;
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_STEPS      = NUM_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   // constants
   localparam int MS_PER_S = 1000;
   localparam logic [DUTY_W-1:0]  DUTY_CAP      = DUTY_W'(1000);
   localparam logic [MS_W-1:0]    TIMEOUT_RESET = MS_W'(500);
   localparam logic [INTEG_W-1:0] INTEG_MAX     = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic [INTEG_W-1:0] INTEG_MIN     = {1'b1, {(INTEG_W-1){1'b0}}};

   // register map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GAIN_W;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DUTY   = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT    = CSR_IDX_W'(5);

   typedef struct packed {
      logic [GAIN_W-1:0]     prop_gain;
      logic [GAIN_W-1:0]     integ_gain;
      logic [GAIN_W-1:0]     deriv_gain;
      logic [DEADBAND_W-1:0] deadband_ticks;
      logic [DUTY_W-1:0]     max_duty;
      logic [MS_W-1:0]       silence_limit_ms;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FAIL,
      ST_MUL_IE,
      ST_ACC,
      ST_MUL_ILO,
      ST_MUL_IHI,
      ST_MUL_D1,
      ST_MUL_D2,
      ST_DIV_I,
      ST_DIV_D_LOAD,
      ST_DIV_D,
      ST_SUM1,
      ST_SUM2,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      MUL_ERR_ELAPSED,
      MUL_ERR_PGAIN,
      MUL_ILO_IGAIN,
      MUL_IHI_IGAIN,
      MUL_DIFF_MS,
      MUL_DPROD_DGAIN
   } mul_sel_type;

   typedef enum logic {
      DIV_SRC_INTEG,
      DIV_SRC_DERIV
   } div_src_type;

   typedef struct packed {
      logic        load;
      logic        clear_state;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        acc;
      logic        pmag_store;
      logic        num_lo;
      logic        num_hi;
      logic        div_start;
      div_src_type div_src;
      logic        imag_store;
      logic        sum_first;
      logic        sum_second;
      logic        rsp_load;
      logic        rsp_failsafe;
   } cmd_type;

   typedef struct packed {
      logic elapsed_zero;
      logic timeout;
      logic div_busy;
      logic div_done;
      logic rsp_free;
   } sts_type;

endpackage

FILE: hdl/ppac_req_if.sv
interface ppac_req_if;
   import ppac_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] target_position;
   logic signed [POS_W-1:0] measured_position;
   logic [MS_W-1:0]         elapsed_ms;
   logic [MS_W-1:0]         ms_since_packet;

   modport source (
      output valid, target_position, measured_position, elapsed_ms, ms_since_packet,
      input  ready
   );

   modport sink (
      input  valid, target_position, measured_position, elapsed_ms, ms_since_packet,
      output ready
   );
endinterface

FILE: hdl/ppac_rsp_if.sv
interface ppac_rsp_if;
   import ppac_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] forward_duty;
   logic [DUTY_W-1:0] reverse_duty;
   logic              failsafe_active;
   logic              in_deadband;

   modport source (
      output valid, forward_duty, reverse_duty, failsafe_active, in_deadband,
      input  ready
   );

   modport sink (
      input  valid, forward_duty, reverse_duty, failsafe_active, in_deadband,
      output ready
   );
endinterface

FILE: hdl/ppac_csr_if.sv
interface ppac_csr_if;
   import ppac_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

FILE: hdl/ppac_div.sv
module ppac_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ppac_pkg::NUM_W-1:0]    dividend,
   input  logic [ppac_pkg::DIV_W-1:0]    divisor,
   output logic                          busy,
   output logic                          done,
   output logic [ppac_pkg::NUM_W-1:0]    quotient
);
   import ppac_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W-1:0]     rem_v;
   logic [NUM_W-1:0]     quo_v;
   logic                 last;

   assign last = busy_ff && (count_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // several restoring steps per cycle, remainder stays below the divisor
   always_comb begin
      rem_v = rem_ff;
      quo_v = quo_ff;
      trial = '0;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         trial = {rem_v, quo_v[NUM_W-1]};
         quo_v = {quo_v[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_v    = DIV_W'(trial - {1'b0, dsr_ff});
            quo_v[0] = 1'b1;
         end else begin
            rem_v = trial[DIV_W-1:0];
         end
      end
   end

   // load on start, then shift quotient bits in
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = quo_v;
         rem_in   = rem_v;
         count_in = DIV_CNT_W'(count_ff + 1'b1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = last;
   assign quotient = quo_ff;

endmodule

FILE: hdl/ppac_dpath.sv
module ppac_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  ppac_pkg::cmd_type                  cmd,
   output ppac_pkg::sts_type                  sts,
   input  ppac_pkg::cfg_type                  cfg,
   input  logic signed [ppac_pkg::POS_W-1:0]  target_position,
   input  logic signed [ppac_pkg::POS_W-1:0]  measured_position,
   input  logic [ppac_pkg::MS_W-1:0]          elapsed_ms,
   input  logic [ppac_pkg::MS_W-1:0]          ms_since_packet,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [ppac_pkg::DUTY_W-1:0]        forward_duty,
   output logic [ppac_pkg::DUTY_W-1:0]        reverse_duty,
   output logic                               failsafe_active,
   output logic                               in_deadband
);
   import ppac_pkg::*;

   // latched item
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [MS_W-1:0]    elapsed_ff, elapsed_in;
   logic [MS_W-1:0]    silence_ff, silence_in;

   // loop state
   logic [INTEG_W-1:0] integ_ff, integ_in;
   logic [ERR_W-1:0]   prev_ff, prev_in;

   // working registers
   logic [DIFF_W-1:0]  diff_ff, diff_in;
   logic [MUL_P_W-1:0] prod_ff, prod_in;
   logic [PMAG_W-1:0]  pmag_ff, pmag_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [SUM_W-1:0]   imag_ff, imag_in;
   logic [SUM_W-1:0]   part_ff, part_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]  fwd_ff, fwd_in;
   logic [DUTY_W-1:0]  rev_ff, rev_in;
   logic               fs_ff, fs_in;
   logic               db_ff, db_in;

   logic [ERR_W-1:0]   err_abs;
   logic [DIFF_W-1:0]  diff_abs;
   logic [INTEG_W-1:0] integ_abs;
   logic [ACC_W-1:0]   term_mag, term_s, acc_sum;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;
   logic [SUM_W-1:0]   p_ext, i_ext, d_ext, p_s, i_s, d_s, sum_abs;
   logic [DRIVE_W-1:0] drive_full;
   logic [DUTY_W-1:0]  limit, drive;
   logic               deadband, sum_pos, sum_neg;
   logic               div_start, div_busy, div_done;
   logic [NUM_W-1:0]   div_num, div_quo;
   logic [DIV_W-1:0]   div_dsr;

   // magnitudes
   assign err_abs   = err_ff[ERR_W-1] ? ERR_W'(~err_ff + 1'b1) : err_ff;
   assign diff_abs  = diff_ff[DIFF_W-1] ? DIFF_W'(~diff_ff + 1'b1) : diff_ff;
   assign integ_abs = integ_ff[INTEG_W-1] ? INTEG_W'(~integ_ff + 1'b1) : integ_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_ERR_ELAPSED: begin
            mul_a = MUL_A_W'(err_abs);
            mul_b = MUL_B_W'(elapsed_ff);
         end
         MUL_ERR_PGAIN: begin
            mul_a = MUL_A_W'(err_abs);
            mul_b = cfg.prop_gain;
         end
         MUL_ILO_IGAIN: begin
            mul_a = MUL_A_W'(integ_abs[INTEG_HALF_W-1:0]);
            mul_b = cfg.integ_gain;
         end
         MUL_IHI_IGAIN: begin
            mul_a = MUL_A_W'(integ_abs[INTEG_W-1:INTEG_HALF_W]);
            mul_b = cfg.integ_gain;
         end
         MUL_DIFF_MS: begin
            mul_a = MUL_A_W'(diff_abs);
            mul_b = MUL_B_W'(MS_PER_S);
         end
         MUL_DPROD_DGAIN: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = cfg.deriv_gain;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   // integral update with saturation
   assign term_mag = ACC_W'(prod_ff[IPROD_W-1:0]);
   assign term_s   = err_ff[ERR_W-1] ? ACC_W'(~term_mag + 1'b1) : term_mag;
   assign acc_sum  = ACC_W'({integ_ff[INTEG_W-1], integ_ff} + term_s);

   // signed terms of the drive sum
   assign p_ext = SUM_W'(pmag_ff);
   assign i_ext = imag_ff;
   assign d_ext = div_quo[SUM_W-1:0];
   assign p_s   = err_ff[ERR_W-1] ? SUM_W'(~p_ext + 1'b1) : p_ext;
   assign i_s   = integ_ff[INTEG_W-1] ? SUM_W'(~i_ext + 1'b1) : i_ext;
   assign d_s   = diff_ff[DIFF_W-1] ? SUM_W'(~d_ext + 1'b1) : d_ext;

   // drive magnitude, clamp and deadband
   assign sum_neg    = sum_ff[SUM_W-1];
   assign sum_pos    = !sum_neg && (sum_ff != '0);
   assign sum_abs    = sum_neg ? SUM_W'(~sum_ff + 1'b1) : sum_ff;
   assign drive_full = sum_abs[SUM_W-1:GAIN_FRAC_BITS];
   assign limit      = (cfg.max_duty > DUTY_CAP) ? DUTY_CAP : cfg.max_duty;
   assign drive      = (drive_full > DRIVE_W'(limit)) ? limit : drive_full[DUTY_W-1:0];
   assign deadband   = err_abs < ERR_W'(cfg.deadband_ticks);

   // divider operands
   assign div_start = cmd.div_start;
   assign div_num   = (cmd.div_src == DIV_SRC_INTEG) ? num_ff : NUM_W'(prod_ff);
   assign div_dsr   = (cmd.div_src == DIV_SRC_INTEG) ? DIV_W'(MS_PER_S) : elapsed_ff;

   ppac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_dsr),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // working register next values
   always_comb begin
      err_in     = err_ff;
      elapsed_in = elapsed_ff;
      silence_in = silence_ff;
      diff_in    = diff_ff;
      prod_in    = prod_ff;
      pmag_in    = pmag_ff;
      num_in     = num_ff;
      imag_in    = imag_ff;
      part_in    = part_ff;
      sum_in     = sum_ff;
      if (cmd.load) begin
         err_in     = ERR_W'({target_position[POS_W-1], target_position}
                             - {measured_position[POS_W-1], measured_position});
         elapsed_in = elapsed_ms;
         silence_in = ms_since_packet;
      end
      if (cmd.mul_go) begin
         prod_in = mul_p;
      end
      if (cmd.acc) begin
         diff_in = DIFF_W'({err_ff[ERR_W-1], err_ff} - {prev_ff[ERR_W-1], prev_ff});
      end
      if (cmd.pmag_store) begin
         pmag_in = prod_ff[PMAG_W-1:0];
      end
      if (cmd.num_lo) begin
         num_in = NUM_W'(prod_ff);
      end
      if (cmd.num_hi) begin
         num_in = NUM_W'(num_ff + NUM_W'({prod_ff, {INTEG_HALF_W{1'b0}}}));
      end
      if (cmd.imag_store) begin
         imag_in = div_quo[SUM_W-1:0];
      end
      if (cmd.sum_first) begin
         part_in = SUM_W'(p_s + i_s);
      end
      if (cmd.sum_second) begin
         sum_in = SUM_W'(part_ff + d_s);
      end
   end

   // loop state next values
   always_comb begin
      integ_in = integ_ff;
      prev_in  = prev_ff;
      if (cmd.clear_state) begin
         integ_in = '0;
         prev_in  = '0;
      end else if (cmd.acc) begin
         prev_in = err_ff;
         if (acc_sum[ACC_W-1] != acc_sum[ACC_W-2]) begin
            integ_in = acc_sum[ACC_W-1] ? INTEG_MIN : INTEG_MAX;
         end else begin
            integ_in = acc_sum[INTEG_W-1:0];
         end
      end else if (cmd.rsp_load && deadband) begin
         integ_in = '0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fwd_in       = fwd_ff;
      rev_in       = rev_ff;
      fs_in        = fs_ff;
      db_in        = db_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         if (cmd.rsp_failsafe) begin
            fwd_in = '0;
            rev_in = '0;
            fs_in  = 1'b1;
            db_in  = 1'b0;
         end else begin
            fwd_in = (!deadband && sum_pos) ? drive : '0;
            rev_in = (!deadband && sum_neg) ? drive : '0;
            fs_in  = 1'b0;
            db_in  = deadband;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      elapsed_ff <= elapsed_in;
      silence_ff <= silence_in;
      diff_ff    <= diff_in;
      prod_ff    <= prod_in;
      pmag_ff    <= pmag_in;
      num_ff     <= num_in;
      imag_ff    <= imag_in;
      part_ff    <= part_in;
      sum_ff     <= sum_in;
      fwd_ff     <= fwd_in;
      rev_ff     <= rev_in;
      fs_ff      <= fs_in;
      db_ff      <= db_in;
   end

   // status toward the controller
   always_comb begin
      sts.elapsed_zero = (elapsed_ff == '0);
      sts.timeout      = silence_ff > cfg.silence_limit_ms;
      sts.div_busy     = div_busy;
      sts.div_done     = div_done;
      sts.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign forward_duty    = fwd_ff;
   assign reverse_duty    = rev_ff;
   assign failsafe_active = fs_ff;
   assign in_deadband     = db_ff;

endmodule

FILE: hdl/ppac_ctrl.sv
`include "pid_position_axis_controller_top_assert.svh"

module ppac_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ppac_pkg::sts_type sts,
   output ppac_pkg::cmd_type cmd
);
   import ppac_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.elapsed_zero) begin
               state_in = ST_IDLE;
            end else if (sts.timeout) begin
               state_in = ST_FAIL;
            end else begin
               state_in = ST_MUL_IE;
            end
         end
         ST_FAIL: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL_IE:  state_in = ST_ACC;
         ST_ACC:     state_in = ST_MUL_ILO;
         ST_MUL_ILO: state_in = ST_MUL_IHI;
         ST_MUL_IHI: state_in = ST_MUL_D1;
         ST_MUL_D1:  state_in = ST_MUL_D2;
         ST_MUL_D2:  state_in = ST_DIV_I;
         ST_DIV_I: begin
            if (sts.div_done) begin
               state_in = ST_DIV_D_LOAD;
            end
         end
         ST_DIV_D_LOAD: state_in = ST_DIV_D;
         ST_DIV_D: begin
            if (sts.div_done) begin
               state_in = ST_SUM1;
            end
         end
         ST_SUM1: state_in = ST_SUM2;
         ST_SUM2: state_in = ST_FIN;
         ST_FIN: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            cmd = '0;
         end
         ST_FAIL: begin
            if (sts.rsp_free) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_failsafe = 1'b1;
               cmd.clear_state  = 1'b1;
            end
         end
         ST_MUL_IE: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_ERR_ELAPSED;
         end
         ST_ACC: begin
            cmd.acc     = 1'b1;
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_ERR_PGAIN;
         end
         ST_MUL_ILO: begin
            cmd.pmag_store = 1'b1;
            cmd.mul_go     = 1'b1;
            cmd.mul_sel    = MUL_ILO_IGAIN;
         end
         ST_MUL_IHI: begin
            cmd.num_lo  = 1'b1;
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_IHI_IGAIN;
         end
         ST_MUL_D1: begin
            cmd.num_hi  = 1'b1;
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_DIFF_MS;
         end
         ST_MUL_D2: begin
            cmd.mul_go    = 1'b1;
            cmd.mul_sel   = MUL_DPROD_DGAIN;
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_INTEG;
         end
         ST_DIV_D_LOAD: begin
            cmd.imag_store = 1'b1;
            cmd.div_start  = 1'b1;
            cmd.div_src    = DIV_SRC_DERIV;
         end
         ST_SUM1: begin
            cmd.sum_first = 1'b1;
         end
         ST_SUM2: begin
            cmd.sum_second = 1'b1;
         end
         ST_FIN: begin
            cmd.rsp_load = sts.rsp_free;
         end
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks on sequencing against the datapath
   `PPAC_ASSERT_IMP(a_div_start_idle, clock, reset, cmd.div_start, !sts.div_busy,
                    "divider started while busy")
   `PPAC_ASSERT_NXT(a_div_runs, clock, reset, cmd.div_start, sts.div_busy,
                    "divider not running after start")
   `PPAC_ASSERT_IMP(a_done_waiting, clock, reset, sts.div_done,
                    (state_ff == ST_DIV_I) || (state_ff == ST_DIV_D),
                    "divider finished outside a wait state")
   `PPAC_ASSERT_NXT(a_load_checks, clock, reset, cmd.load, state_ff == ST_CHECK,
                    "accepted item not checked next")

endmodule

FILE: hdl/pid_position_axis_controller_top.sv
// channel   dir  handshake     payload
// req_bus   in   valid/ready   target_position, measured_position, elapsed_ms, ms_since_packet
// rsp_bus   out  valid/ready   forward_duty, reverse_duty, failsafe_active, in_deadband
// csr_bus   in   valid/ready   index, data (always ready)
//
// a normal tick goes from one transfer to the earliest next one through the check, the
// shared multiplier steps, two passes through the radix-16 long divider and the sums
// a packet timeout tick goes from the check to failsafe; a zero elapsed tick gives no result
// the result sits in an output register, so the next tick is taken while it waits
// the sequencer holds in its last state while an earlier result is still not taken
// synchronous reset clears the integral, previous error, control state and result valid flag
module pid_position_axis_controller_top (
   input logic        clock,
   input logic        reset,
   ppac_req_if.sink   req_bus,
   ppac_rsp_if.source rsp_bus,
   ppac_csr_if.sink   csr_bus
);
   import ppac_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   sts_type sts;
   logic    req_ready;
   logic    csr_fire;

   // configuration registers
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         case (csr_bus.index)
            REG_PROP_GAIN:  cfg_in.prop_gain        = csr_bus.data[GAIN_W-1:0];
            REG_INTEG_GAIN: cfg_in.integ_gain       = csr_bus.data[GAIN_W-1:0];
            REG_DERIV_GAIN: cfg_in.deriv_gain       = csr_bus.data[GAIN_W-1:0];
            REG_DEADBAND:   cfg_in.deadband_ticks   = csr_bus.data[DEADBAND_W-1:0];
            REG_MAX_DUTY:   cfg_in.max_duty         = csr_bus.data[DUTY_W-1:0];
            REG_TIMEOUT:    cfg_in.silence_limit_ms = csr_bus.data[MS_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= '0;
         cfg_ff.integ_gain       <= '0;
         cfg_ff.deriv_gain       <= '0;
         cfg_ff.deadband_ticks   <= '0;
         cfg_ff.max_duty         <= DUTY_CAP;
         cfg_ff.silence_limit_ms <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   assign req_bus.ready = req_ready;

   ppac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and result register
   ppac_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg               (cfg_ff),
      .target_position   (req_bus.target_position),
      .measured_position (req_bus.measured_position),
      .elapsed_ms        (req_bus.elapsed_ms),
      .ms_since_packet   (req_bus.ms_since_packet),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .forward_duty      (rsp_bus.forward_duty),
      .reverse_duty      (rsp_bus.reverse_duty),
      .failsafe_active   (rsp_bus.failsafe_active),
      .in_deadband       (rsp_bus.in_deadband)
   );

endmodule
